### design/sla_pkg.sv
`timescale 1ns / 1ps

package sla_pkg;

    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] PRINT_FIRST   = 8'h20;
    localparam logic [7:0] PRINT_END     = 8'h7F;
    localparam logic [6:0] OUT_LIMIT_RST = 7'd64;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic {
        CMD_STORE,
        CMD_END
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [6:0] ch;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } back_state_t;

endpackage

### design/sla_if.sv
`timescale 1ns / 1ps

interface sla_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sla_line_if;
    logic       valid;
    logic       ready;
    logic [6:0] line_char;
    logic       has_char;
    logic [5:0] line_length;
    logic       last_of_line;

    modport source (output valid, output line_char, output has_char,
                    output line_length, output last_of_line, input ready);
    modport sink (input valid, input line_char, input has_char,
                  input line_length, input last_of_line, output ready);
endinterface

### design/serial_line_assembler.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Request
// rx        in   rx_byte[7:0]                                     valid & ready
// line      out  line_char[6:0] has_char line_length[5:0] last    valid & ready
// cfg       in   cfg_wr_data[6:0] = out_limit                     cfg_wr_en
//
// Each received byte is taken while the four-entry command queue has room.
// The back end takes a stored character in ST_IDLE. A terminator is taken in ST_IDLE,
// then each character handed out passes ST_READ (line memory read), then ST_EMIT (output register).
// An empty line is taken in ST_IDLE and written straight to the output register.
// rst_n clears the count, the queue and the output valid flag; out_limit returns to 64.
// A stalled reader holds the back end but for ST_IDLE stores; the queue takes bytes until it fills.

module serial_line_assembler
    import sla_pkg::*;
#(
    parameter int unsigned LINE_CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    sla_rx_if.sink      rx,
    sla_line_if.source  line,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);

    logic [6:0] out_limit_reg;
    logic       push_valid;
    logic       push_ready;
    cmd_t       push_cmd;
    logic       pop_valid;
    logic       pop_ready;
    cmd_t       pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_limit_reg <= OUT_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            out_limit_reg <= cfg_wr_data;
        end
    end

    sla_front u_front
    (
        .rx         (rx),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    sla_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    sla_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_ready (pop_ready),
        .out_limit (out_limit_reg),
        .line      (line)
    );

    // An empty line is always a single result.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && !line.has_char |-> line.last_of_line && line.line_length == '0)
        else $error("empty-line result not marked last");

    a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && line.has_char |->
            line.line_char >= 7'h20 && line.line_char != 7'h7F && line.line_length != '0)
        else $error("handed-out character is not printable or length is zero");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> out_limit_reg == $past(cfg_wr_data))
        else $error("out_limit write lost");

    a_queue_classified: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_cmd.op == CMD_STORE |-> push_cmd.ch >= 7'h20 && push_cmd.ch != 7'h7F)
        else $error("non-printable byte queued for storage");

endmodule

### design/sla_front.sv
`timescale 1ns / 1ps

module sla_front
    import sla_pkg::*;
(
    sla_rx_if.sink rx,
    output logic   push_valid,
    output cmd_t   push_cmd,
    input  logic   push_ready
);

    logic is_term;
    logic is_print;

    always_comb
    begin
        is_term  = (rx.rx_byte == BYTE_LF) || (rx.rx_byte == BYTE_CR);
        is_print = (rx.rx_byte >= PRINT_FIRST) && (rx.rx_byte < PRINT_END);
    end

    // Bytes that are neither printable nor a terminator are taken and dropped here.
    assign rx.ready    = push_ready;
    assign push_valid  = rx.valid && (is_term || is_print);
    assign push_cmd.op = is_term ? CMD_END : CMD_STORE;
    assign push_cmd.ch = rx.rx_byte[6:0];

endmodule

### design/sla_cmd_fifo.sv
`timescale 1ns / 1ps

module sla_cmd_fifo
    import sla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    cmd_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     fill_reg;
    logic [FIFO_AW:0]     fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (fill_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/sla_back.sv
`timescale 1ns / 1ps

module sla_back
    import sla_pkg::*;
#(
    parameter int unsigned LINE_CAPACITY = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  cmd_t         cmd,
    output logic         cmd_ready,
    input  logic [6:0]   out_limit,
    sla_line_if.source   line
);

    localparam int unsigned DEPTH = LINE_CAPACITY - 1;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(LINE_CAPACITY);

    back_state_t     state_reg;
    back_state_t     state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   n_next;
    logic [AW-1:0]   k_reg;
    logic [AW-1:0]   k_next;

    logic [6:0]      line_mem [DEPTH];
    logic [6:0]      rd_data_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [6:0]      out_char_reg;
    logic [6:0]      out_char_next;
    logic            out_has_reg;
    logic            out_has_next;
    logic [5:0]      out_len_reg;
    logic [5:0]      out_len_next;
    logic            out_last_reg;
    logic            out_last_next;

    logic            out_free;
    logic            take_cmd;
    logic            mem_we;
    logic            mem_re;
    logic            is_last;
    logic [6:0]      lim_eff;
    logic [CW-1:0]   n_calc;

    assign out_free = !out_valid_reg || line.ready;
    assign take_cmd = cmd_valid && cmd_ready;
    assign is_last  = ((CW + 1)'(k_reg) + 1'b1) == (CW + 1)'(n_reg);

    // A limit of zero behaves as one; the count is the smaller of the two.
    always_comb
    begin
        lim_eff = (out_limit == '0) ? 7'd1 : out_limit;
        n_calc  = (7'(count_reg) < lim_eff) ? count_reg : lim_eff[CW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_cmd && cmd.op == CMD_END && count_reg != '0)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        count_next     = count_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !line.ready;
        out_char_next  = out_char_reg;
        out_has_next   = out_has_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = out_free || (cmd.op == CMD_STORE);
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd.op == CMD_STORE)
                    begin
                        if (count_reg < CW'(DEPTH))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = '0;
                        out_has_next   = 1'b0;
                        out_len_next   = '0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        n_next = n_calc;
                        k_next = '0;
                    end
                end
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data_reg;
                    out_has_next   = 1'b1;
                    out_len_next   = 6'(count_reg);
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_has_reg  <= out_has_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[count_reg[AW-1:0]] <= cmd.ch;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[k_reg];
        end
    end

    assign line.valid        = out_valid_reg;
    assign line.line_char    = out_char_reg;
    assign line.has_char     = out_has_reg;
    assign line.line_length  = out_len_reg;
    assign line.last_of_line = out_last_reg;

endmodule

### tb/serial_line_assembler_tb.sv
`timescale 1ns / 1ps

module serial_line_assembler_tb
    import sla_pkg::*;
;

    localparam int LINE_CAPACITY = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DIR_ROWS      = 23;
    localparam int PHASE_ITEMS   = 3;
    localparam int LONG_LINE     = 64;

    typedef struct packed {
        logic [6:0] line_char;
        logic       has_char;
        logic [5:0] line_length;
        logic       last_of_line;
    } line_result_t;

    typedef struct packed {
        logic [7:0]   rx_byte;
        logic         typed;
        line_result_t result;
    } dir_row_t;

    localparam line_result_t EMPTY_LINE = '{7'd0, 1'b0, 6'd0, 1'b1};
    localparam line_result_t NO_RESULT  = '{7'd0, 1'b0, 6'd0, 1'b0};

    // Rows marked typed carry their one result; the rest go through the predictor.
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{BYTE_LF, 1'b1, EMPTY_LINE},
        '{BYTE_CR, 1'b1, EMPTY_LINE},
        '{PRINT_FIRST, 1'b0, NO_RESULT},
        '{8'h7E, 1'b0, NO_RESULT},
        '{PRINT_END, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h1F, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h09, 1'b0, NO_RESULT},
        '{8'h0B, 1'b0, NO_RESULT},
        '{8'h0C, 1'b0, NO_RESULT},
        '{8'h0E, 1'b0, NO_RESULT},
        '{BYTE_CR, 1'b0, NO_RESULT},
        '{PRINT_END, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{BYTE_LF, 1'b1, EMPTY_LINE},
        '{8'h5A, 1'b0, NO_RESULT},
        '{BYTE_CR, 1'b1, '{7'h5A, 1'b1, 6'd1, 1'b1}},
        '{8'h41, 1'b0, NO_RESULT},
        '{8'h42, 1'b0, NO_RESULT},
        '{8'h43, 1'b0, NO_RESULT},
        '{BYTE_LF, 1'b0, NO_RESULT}
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [6:0] cfg_wr_data;

    sla_rx_if   rx ();
    sla_line_if line ();

    serial_line_assembler #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx),
        .line(line),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Shadow of the line store, its count and the output limit.
    logic [6:0]   held_chars [LINE_CAPACITY-1];
    int           held_count = 0;
    int           shadow_limit = OUT_LIMIT_RST;
    line_result_t line_results_due [$];

    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int drain_cycle = 0;
    int drain_mode = 0;
    int drain_hold = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Reader stall pattern: stretches of full speed, random stalls and long holds.
    always @(posedge clk)
    begin
        drain_cycle <= drain_cycle + 1;
        if (drain_cycle % 64 == 0)
        begin
            drain_mode <= $urandom_range(0, 2);
        end
        if (drain_hold > 0)
        begin
            drain_hold <= drain_hold - 1;
            line.ready <= 1'b0;
        end
        else if (drain_mode == 1)
        begin
            line.ready <= ($urandom_range(0, 2) != 0);
        end
        else if (drain_mode == 2 && $urandom_range(0, 9) == 0)
        begin
            drain_hold <= $urandom_range(4, 24);
            line.ready <= 1'b0;
        end
        else
        begin
            line.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        line_result_t got;
        line_result_t want;
        if (rst_n && line.valid && line.ready)
        begin
            got = '{line.line_char, line.has_char, line.line_length, line.last_of_line};
            if (line_results_due.size() == 0)
            begin
                $display("%0t: unexpected line result char=%h has=%b len=%0d last=%b",
                         $time, got.line_char, got.has_char, got.line_length,
                         got.last_of_line);
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = line_results_due.pop_front();
                if (got.line_char !== want.line_char || got.has_char !== want.has_char ||
                    got.line_length !== want.line_length ||
                    got.last_of_line !== want.last_of_line)
                begin
                    $display("%0t: expected char=%h has=%b len=%0d last=%b,",
                             $time, want.line_char, want.has_char, want.line_length,
                             want.last_of_line,
                             " got char=%h has=%b len=%0d last=%b",
                             got.line_char, got.has_char, got.line_length,
                             got.last_of_line);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Applies one accepted byte to the shadow state; a terminator hands out the line.
    task automatic assemble_byte(input logic [7:0] b, input bit keep);
        int take;
        int k;
        if (b == BYTE_LF || b == BYTE_CR)
        begin
            if (held_count == 0)
            begin
                if (keep)
                begin
                    line_results_due.push_back(EMPTY_LINE);
                end
            end
            else
            begin
                take = (shadow_limit < 1) ? 1 : shadow_limit;
                if (take > held_count)
                begin
                    take = held_count;
                end
                for (k = 0; k < take; k++)
                begin
                    if (keep)
                    begin
                        line_results_due.push_back('{held_chars[k], 1'b1, 6'(held_count),
                                                     (k == take - 1)});
                    end
                end
            end
            held_count = 0;
        end
        else if (b >= PRINT_FIRST && b < PRINT_END && held_count < LINE_CAPACITY - 1)
        begin
            held_chars[held_count] = b[6:0];
            held_count++;
        end
    endtask

    // Returns at the clock edge where the request is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                rx.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_byte(b);
        assemble_byte(b, 1'b1);
    endtask

    task automatic wait_drained();
        rx.valid <= 1'b0;
        while (line_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_out_limit(input logic [6:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_limit = value;
    endtask

    // Lines of random length, mostly printable with some noise, each ended by CR or LF.
    task automatic run_lines(input int item_goal, input bit long_first);
        int sent;
        int len;
        int k;
        logic [7:0] b;
        sent = 0;
        if (long_first)
        begin
            for (k = 0; k < LONG_LINE; k++)
            begin
                feed_byte(8'($urandom_range(PRINT_FIRST, PRINT_END - 1)));
            end
            feed_byte(BYTE_CR);
        end
        while (sent < item_goal)
        begin
            len = $urandom_range(0, 8);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    b = 8'($urandom_range(PRINT_FIRST, PRINT_END - 1));
                end
                else
                begin
                    b = 8'($urandom_range(0, 255));
                end
                feed_byte(b);
            end
            feed_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            sent += len + 1;
        end
    endtask

    initial
    begin
        int i;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        rx.valid <= 1'b0;
        rx.rx_byte <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_byte(DIRECTED_ROWS[i].rx_byte);
            if (DIRECTED_ROWS[i].typed)
            begin
                line_results_due.push_back(DIRECTED_ROWS[i].result);
            end
            assemble_byte(DIRECTED_ROWS[i].rx_byte, !DIRECTED_ROWS[i].typed);
        end
        run_lines(PHASE_ITEMS, 1'b0);
        wait_drained();

        // A limit of zero behaves as one; 127 lies above the line capacity.
        write_out_limit(7'd1);
        run_lines(PHASE_ITEMS, 1'b0);
        wait_drained();
        write_out_limit(7'd0);
        run_lines(PHASE_ITEMS, 1'b0);
        wait_drained();
        write_out_limit(7'd127);
        run_lines(PHASE_ITEMS, 1'b1);
        wait_drained();
        write_out_limit(7'd3);
        run_lines(PHASE_ITEMS, 1'b0);
        wait_drained();
        write_out_limit(7'($urandom_range(1, 64)));
        run_lines(PHASE_ITEMS, 1'b0);
        wait_drained();
        write_out_limit(OUT_LIMIT_RST);
        run_lines(PHASE_ITEMS, 1'b0);
        wait_drained();

        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### serial_line_assembler.f
design/sla_pkg.sv
design/sla_if.sv
design/sla_front.sv
design/sla_cmd_fifo.sv
design/sla_back.sv
design/serial_line_assembler.sv
tb/serial_line_assembler_tb.sv
